// File: rtl/ccb_pkg.sv
// Package for the clipped color-key blitter.
// Holds register codes, field widths, the key color and the stage record.
// No dependencies.
package ccb_pkg;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned POS_W   = 12;

  localparam logic [PIXEL_W-1:0] KEY_COLOR = 16'hF81F;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_KEY_ENABLE    = 3'd4
  } reg_e;

  typedef struct packed {
    logic [POS_W-1:0]   screen_x;
    logic [POS_W-1:0]   screen_y;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } stage_t;

endpackage

// File: rtl/ccb_count.sv
// Source position counter and input register of the blitter.
// Tracks column and row, forms screen coordinates and the last-pixel flag.
// Depends on ccb_pkg.
module ccb_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ccb_pkg::CFG_W-1:0]     dest_x_i,
  input  logic [ccb_pkg::CFG_W-1:0]     dest_y_i,
  input  logic [ccb_pkg::CFG_W-1:0]     source_width_i,
  input  logic [ccb_pkg::CFG_W-1:0]     source_height_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ccb_pkg::PIXEL_W-1:0]   pixel_i,
  output logic                          stg_valid_o,
  input  logic                          stg_ready_i,
  output ccb_pkg::stage_t               stg_o
);

  logic [ccb_pkg::CNT_W-1:0] col_q, col_d;
  logic [ccb_pkg::CNT_W-1:0] row_q, row_d;
  logic                      vld_q, vld_d;
  ccb_pkg::stage_t           stg_q, stg_d;
  logic [ccb_pkg::CNT_W-1:0] width_m1, height_m1;
  logic                      row_end, last, accept;

  function automatic logic [ccb_pkg::CNT_W-1:0] side_m1(input logic [ccb_pkg::CFG_W-1:0] v);
    logic [ccb_pkg::CNT_W-1:0] r;
    if (v[ccb_pkg::CFG_W-1]) begin
      r = '1;
    end else if (v == '0) begin
      r = '0;
    end else begin
      r = v[ccb_pkg::CNT_W-1:0] - ccb_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  assign width_m1   = side_m1(source_width_i);
  assign height_m1  = side_m1(source_height_i);
  assign row_end    = col_q >= width_m1;
  assign last       = row_end && (row_q >= height_m1);
  assign in_ready_o = !vld_q || stg_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    vld_d = vld_q;
    stg_d = stg_q;
    if (accept) begin
      vld_d          = 1'b1;
      stg_d.screen_x = {dest_x_i[ccb_pkg::CFG_W-1], dest_x_i} + ccb_pkg::POS_W'(col_q);
      stg_d.screen_y = {dest_y_i[ccb_pkg::CFG_W-1], dest_y_i} + ccb_pkg::POS_W'(row_q);
      stg_d.pixel    = pixel_i;
      stg_d.last     = last;
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + ccb_pkg::CNT_W'(1);
      end else begin
        col_d = col_q + ccb_pkg::CNT_W'(1);
      end
    end else if (stg_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      vld_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign stg_valid_o = vld_q;
  assign stg_o       = stg_q;

endmodule

// File: rtl/ccb_place.sv
// Clipping, color keying and address stage of the blitter.
// Forms the frame-buffer address and write enable into the result register.
// Depends on ccb_pkg.
module ccb_place #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          key_enable_i,
  input  logic                          stg_valid_i,
  output logic                          stg_ready_o,
  input  ccb_pkg::stage_t               stg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          write_enable_o,
  output logic [ccb_pkg::ADDR_W-1:0]    screen_address_o,
  output logic [ccb_pkg::PIXEL_W-1:0]   write_pixel_o,
  output logic                          last_pixel_o
);

  localparam int unsigned PROD_W = 2 * ccb_pkg::CNT_W;

  logic                          vld_q, vld_d;
  logic                          we_q, we_d;
  logic [ccb_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [ccb_pkg::PIXEL_W-1:0]   pix_q, pix_d;
  logic                          last_q, last_d;
  logic                          on_x, on_y, on, keyed, load;
  logic [PROD_W-1:0]             offset;

  assign on_x = !stg_i.screen_x[ccb_pkg::POS_W-1] &&
                (stg_i.screen_x[ccb_pkg::POS_W-2:0] < ccb_pkg::CFG_W'(SCREEN_WIDTH));
  assign on_y = !stg_i.screen_y[ccb_pkg::POS_W-1] &&
                (stg_i.screen_y[ccb_pkg::POS_W-2:0] < ccb_pkg::CFG_W'(SCREEN_HEIGHT));
  assign on    = on_x && on_y;
  assign keyed = key_enable_i && (stg_i.pixel == ccb_pkg::KEY_COLOR);

  assign offset = PROD_W'(stg_i.screen_y[ccb_pkg::CNT_W-1:0]) * PROD_W'(SCREEN_WIDTH)
                + PROD_W'(stg_i.screen_x[ccb_pkg::CNT_W-1:0]);

  assign stg_ready_o = !vld_q || out_ready_i;
  assign load        = stg_valid_i && stg_ready_o;

  always_comb begin
    vld_d  = vld_q;
    we_d   = we_q;
    addr_d = addr_q;
    pix_d  = pix_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      we_d   = on && !keyed;
      addr_d = on ? offset[ccb_pkg::ADDR_W-1:0] : '0;
      pix_d  = stg_i.pixel;
      last_d = stg_i.last;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    we_q   <= we_d;
    addr_q <= addr_d;
    pix_q  <= pix_d;
    last_q <= last_d;
  end

  assign out_valid_o      = vld_q;
  assign write_enable_o   = we_q;
  assign screen_address_o = addr_q;
  assign write_pixel_o    = pix_q;
  assign last_pixel_o     = last_q;

endmodule

// File: rtl/clipped_color_key_blitter_top.sv
// Top level of the clipped color-key blitter: register port and stream glue.
// Instantiates ccb_count and ccb_place and uses ccb_pkg.
//
// The blitter takes one RGB565 source pixel per clock in raster order and
// gives one result per pixel: the frame-buffer address, a write enable, the
// pixel and a last-pixel mark (tlast) on the final pixel of the image. A
// pixel passes through two registers, the input register and then the
// result register; both stages move every cycle, so the sustained
// rate is one pixel per clock whenever the downstream side takes results.
// Pixels outside the screen give address zero and no write; pixels equal to
// 0xF81F give no write while keying is on. The user must write registers only while
// no pixel is in flight (not enforced); a write does not clear the position counters.
module clipped_color_key_blitter_top #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] source_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [18:0] screen_address, [34:19] write_pixel, rest zero
  output logic        m_axis_tuser,   // [0] write_enable
  output logic        m_axis_tlast
);

  logic [ccb_pkg::CFG_W-1:0]   dest_x_q, dest_y_q, width_q, height_q;
  logic                        key_en_q;
  logic                        wr_en;
  ccb_pkg::reg_e               reg_sel;
  logic                        stg_valid, stg_ready;
  ccb_pkg::stage_t             stg;
  logic [ccb_pkg::ADDR_W-1:0]  screen_address;
  logic [ccb_pkg::PIXEL_W-1:0] write_pixel;

  assign pready  = 1'b1;
  assign reg_sel = ccb_pkg::reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      width_q  <= ccb_pkg::CFG_W'(1);
      height_q <= ccb_pkg::CFG_W'(1);
      key_en_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        ccb_pkg::REG_DEST_X:        dest_x_q <= pwdata[ccb_pkg::CFG_W-1:0];
        ccb_pkg::REG_DEST_Y:        dest_y_q <= pwdata[ccb_pkg::CFG_W-1:0];
        ccb_pkg::REG_SOURCE_WIDTH:  width_q  <= pwdata[ccb_pkg::CFG_W-1:0];
        ccb_pkg::REG_SOURCE_HEIGHT: height_q <= pwdata[ccb_pkg::CFG_W-1:0];
        ccb_pkg::REG_KEY_ENABLE:    key_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ccb_pkg::REG_DEST_X:        prdata = 32'(dest_x_q);
      ccb_pkg::REG_DEST_Y:        prdata = 32'(dest_y_q);
      ccb_pkg::REG_SOURCE_WIDTH:  prdata = 32'(width_q);
      ccb_pkg::REG_SOURCE_HEIGHT: prdata = 32'(height_q);
      ccb_pkg::REG_KEY_ENABLE:    prdata = 32'(key_en_q);
      default:                    prdata = '0;
    endcase
  end

  ccb_count u_count (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dest_x_i        (dest_x_q),
    .dest_y_i        (dest_y_q),
    .source_width_i  (width_q),
    .source_height_i (height_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .pixel_i         (s_axis_tdata),
    .stg_valid_o     (stg_valid),
    .stg_ready_i     (stg_ready),
    .stg_o           (stg)
  );

  ccb_place #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_place (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_enable_i     (key_en_q),
    .stg_valid_i      (stg_valid),
    .stg_ready_o      (stg_ready),
    .stg_i            (stg),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .write_enable_o   (m_axis_tuser),
    .screen_address_o (screen_address),
    .write_pixel_o    (write_pixel),
    .last_pixel_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, write_pixel, screen_address};

`ifndef NO_ASSERTIONS
  localparam int unsigned SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> ({2'b0, screen_address} < 21'(SCREEN_PIXELS)))
    else $error("write enabled at an address beyond the screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && key_en_q && (write_pixel == ccb_pkg::KEY_COLOR) |-> !m_axis_tuser)
    else $error("key color written while keying is on");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && stg_valid)
    else $error("input stalled while the pipeline has room");
`endif

endmodule
